// ===== src/vrt_pkg.sv =====
package vrt_pkg;

	localparam int GRID_BITS_DEF = 5;
	localparam int FRAC_BITS_DEF = 16;

	localparam int ORG_W      = 24;
	localparam int DIR_W      = 16;
	localparam int MAG_W      = 16;
	localparam int CIN_W      = 5;
	localparam int MAXD_W     = 8;
	localparam int IN_DATA_W  = 136;
	localparam int OUT_DATA_W = 32;
	localparam int CX_LSB     = 0;
	localparam int CY_LSB     = 5;
	localparam int CZ_LSB     = 10;
	localparam int ORG_LSB    = 15;
	localparam int DIR_LSB    = 87;

	localparam logic [MAXD_W-1:0] MAXD_RESET = 8'd10;

	// Setup sequence of the shared multiplier, one product per cycle.
	localparam logic [4:0] SU_LEN = 5'd0;   // squared magnitudes into the length
	localparam logic [4:0] SU_MD  = 5'd3;   // limit times magnitude
	localparam logic [4:0] SU_T   = 5'd6;   // squared limit terms
	localparam logic [4:0] SU_P   = 5'd9;   // cross products of crossings
	localparam logic [4:0] SU_R   = 5'd15;  // crossing times squared length
	localparam logic [4:0] SU_QL  = 5'd18;  // low half of squared distance
	localparam logic [4:0] SU_QH  = 5'd21;  // high half of squared distance
	localparam logic [4:0] SU_END = 5'd24;

	typedef enum logic [1:0] {
		OP_CAST = 2'd0,
		OP_SET  = 2'd1,
		OP_CLR  = 2'd2,
		OP_NOP  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		K_CAST = 2'd0,
		K_SET  = 2'd1,
		K_CLR  = 2'd2,
		K_MISS = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_WR_RD,
		ST_WR_WB,
		ST_SETUP,
		ST_WALK_CHK,
		ST_WALK_TEST,
		ST_DONE
	} back_state_t;

	// Width of one queue entry between the front and the back.
	function automatic int entry_bits(input int g, input int f);
		return 2 + 3 * g + 6 + 3 * (ORG_W - f) + 3 * MAG_W + 3 * (f + 1);
	endfunction

endpackage

// ===== src/voxel_ray_traversal.sv =====
// Steps: a set or clear word goes from the queue through a row read and a write-back
// to the output register, a miss straight there; a cast runs the setup sequence on the
// shared multiplier, then one grid step per cell (one limit check, one occupancy row read).
// Throughput: the back end works on one word at a time; a front register and a two-word
// queue accept the next words meanwhile. Reset clears the occupancy one row per cycle,
// all 2^(2*GRID_BITS) rows (1024 by default), during which no word is accepted.
module voxel_ray_traversal #(
	parameter int GRID_BITS = vrt_pkg::GRID_BITS_DEF,
	parameter int FRAC_BITS = vrt_pkg::FRAC_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	// cell_x, cell_y, cell_z, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z
	input  logic [vrt_pkg::IN_DATA_W-1:0]   s_axis_tdata,
	// opcode
	input  logic [1:0]                      s_axis_tuser,
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	// hit_x, hit_y, hit_z, normal_axis, normal_negative
	output logic [vrt_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
	// hit
	output logic [0:0]                      m_axis_tuser,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [vrt_pkg::MAXD_W-1:0]      cfg_data
);

	localparam int EW = vrt_pkg::entry_bits(GRID_BITS, FRAC_BITS);

	logic [vrt_pkg::MAXD_W-1:0] max_distance_q;
	logic                       clearing;
	logic                       fq_in_valid;
	logic                       fq_in_ready;
	logic [EW-1:0]              fq_in_data;
	logic                       fq_out_valid;
	logic                       fq_out_ready;
	logic [EW-1:0]              fq_out_data;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_distance_q <= vrt_pkg::MAXD_RESET;
		end else if (cfg_valid) begin
			max_distance_q <= cfg_data;
		end
	end

	vrt_front #(
		.GRID_BITS(GRID_BITS),
		.FRAC_BITS(FRAC_BITS)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.hold(clearing),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.q_valid(fq_in_valid),
		.q_ready(fq_in_ready),
		.q_data(fq_in_data)
	);

	vrt_fifo #(
		.W(EW)
	) u_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(fq_in_valid),
		.in_ready(fq_in_ready),
		.in_data(fq_in_data),
		.out_valid(fq_out_valid),
		.out_ready(fq_out_ready),
		.out_data(fq_out_data)
	);

	vrt_back #(
		.GRID_BITS(GRID_BITS),
		.FRAC_BITS(FRAC_BITS)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.max_distance(max_distance_q),
		.q_valid(fq_out_valid),
		.q_ready(fq_out_ready),
		.q_data(fq_out_data),
		.clearing(clearing),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser)
	);

endmodule

// ===== src/vrt_fifo.sv =====
module vrt_fifo #(
	parameter int W = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_ready,
	input  logic [W-1:0] in_data,
	output logic         out_valid,
	input  logic         out_ready,
	output logic [W-1:0] out_data
);

	logic [W-1:0] slot_q [2];
	logic         wp_q;
	logic         rp_q;
	logic [1:0]   cnt_q;
	logic         push;
	logic         pop;

	assign in_ready  = (cnt_q != 2'd2);
	assign out_valid = (cnt_q != 2'd0);
	assign out_data  = slot_q[rp_q];
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= !wp_q;
			if (pop) rp_q <= !rp_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) slot_q[wp_q] <= in_data;
	end

endmodule

// ===== src/vrt_front.sv =====
module vrt_front #(
	parameter int GRID_BITS = vrt_pkg::GRID_BITS_DEF,
	parameter int FRAC_BITS = vrt_pkg::FRAC_BITS_DEF,
	localparam int EW = vrt_pkg::entry_bits(GRID_BITS, FRAC_BITS)
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           hold,
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	input  logic [vrt_pkg::IN_DATA_W-1:0]  s_axis_tdata,
	input  logic [1:0]                     s_axis_tuser,
	output logic                           q_valid,
	input  logic                           q_ready,
	output logic [EW-1:0]                  q_data
);

	localparam int CW0 = vrt_pkg::ORG_W - FRAC_BITS;

	typedef struct packed {
		vrt_pkg::kind_t                      kind;
		logic [2*GRID_BITS-1:0]              waddr;
		logic [GRID_BITS-1:0]                wbit;
		logic [2:0]                          pos;
		logic [2:0]                          live;
		logic [2:0][CW0-1:0]                 cidx;
		logic [2:0][vrt_pkg::MAG_W-1:0]      mag;
		logic [2:0][FRAC_BITS:0]             nxt0;
	} entry_t;

	localparam logic [FRAC_BITS:0] ONE_CELL = (FRAC_BITS+1)'(1) << FRAC_BITS;

	entry_t ent_d;
	entry_t ent_s1;
	logic   v_s1;
	logic   accept;

	assign s_axis_tready = !hold && (!v_s1 || q_ready);
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign q_valid       = v_s1;
	assign q_data        = ent_s1;

	always_comb begin
		logic [vrt_pkg::ORG_W-1:0] org;
		logic [vrt_pkg::DIR_W-1:0] dir;
		logic [FRAC_BITS-1:0]      frac;
		logic [vrt_pkg::CIN_W-1:0] cx;
		logic [vrt_pkg::CIN_W-1:0] cy;
		logic [vrt_pkg::CIN_W-1:0] cz;
		logic                      in_grid;
		cx = s_axis_tdata[vrt_pkg::CX_LSB +: vrt_pkg::CIN_W];
		cy = s_axis_tdata[vrt_pkg::CY_LSB +: vrt_pkg::CIN_W];
		cz = s_axis_tdata[vrt_pkg::CZ_LSB +: vrt_pkg::CIN_W];
		ent_d.waddr = {GRID_BITS'(cz), GRID_BITS'(cy)};
		ent_d.wbit  = GRID_BITS'(cx);
		// A write to a cell beyond a small grid is dropped.
		in_grid = ((cx >> GRID_BITS) == '0) && ((cy >> GRID_BITS) == '0) &&
			((cz >> GRID_BITS) == '0);
		for (int a = 0; a < 3; a++) begin
			org  = s_axis_tdata[vrt_pkg::ORG_LSB + a*vrt_pkg::ORG_W +: vrt_pkg::ORG_W];
			dir  = s_axis_tdata[vrt_pkg::DIR_LSB + a*vrt_pkg::DIR_W +: vrt_pkg::DIR_W];
			frac = org[FRAC_BITS-1:0];
			ent_d.cidx[a] = org[vrt_pkg::ORG_W-1:FRAC_BITS];
			ent_d.live[a] = (dir != '0);
			ent_d.pos[a]  = !dir[vrt_pkg::DIR_W-1] && (dir != '0);
			ent_d.mag[a]  = dir[vrt_pkg::DIR_W-1] ? vrt_pkg::MAG_W'(-dir) : dir;
			ent_d.nxt0[a] = ent_d.pos[a] ? ONE_CELL - (FRAC_BITS+1)'(frac)
				: (FRAC_BITS+1)'(frac);
		end
		unique case (vrt_pkg::op_t'(s_axis_tuser)) inside
			vrt_pkg::OP_CAST:
				ent_d.kind = (ent_d.live == 3'b000) ? vrt_pkg::K_MISS : vrt_pkg::K_CAST;
			vrt_pkg::OP_SET, vrt_pkg::OP_CLR: begin
				if (!in_grid) ent_d.kind = vrt_pkg::K_MISS;
				else if (vrt_pkg::op_t'(s_axis_tuser) == vrt_pkg::OP_SET)
					ent_d.kind = vrt_pkg::K_SET;
				else ent_d.kind = vrt_pkg::K_CLR;
			end
			default: ent_d.kind = vrt_pkg::K_MISS;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= accept || (v_s1 && !q_ready);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) ent_s1 <= ent_d;
	end

endmodule

// ===== src/vrt_back.sv =====
module vrt_back #(
	parameter int GRID_BITS = vrt_pkg::GRID_BITS_DEF,
	parameter int FRAC_BITS = vrt_pkg::FRAC_BITS_DEF,
	localparam int EW = vrt_pkg::entry_bits(GRID_BITS, FRAC_BITS)
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic [vrt_pkg::MAXD_W-1:0]      max_distance,
	input  logic                            q_valid,
	output logic                            q_ready,
	input  logic [EW-1:0]                   q_data,
	output logic                            clearing,
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	output logic [vrt_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
	output logic [0:0]                      m_axis_tuser
);

	localparam int CW0  = vrt_pkg::ORG_W - FRAC_BITS;
	localparam int CW   = 34 - FRAC_BITS;
	localparam int NW   = FRAC_BITS + 10;
	localparam int PW   = NW + 16;
	localparam int RW   = NW + 32;
	localparam int QW   = 2 * NW + 32;
	localparam int QSW  = QW - 2 * FRAC_BITS;
	localparam int TW   = 48;
	localparam int MDW  = 24;
	localparam int RAW  = 2 * GRID_BITS;
	localparam int ROWS = 1 << RAW;
	localparam int ROWW = 1 << GRID_BITS;

	typedef struct packed {
		vrt_pkg::kind_t                      kind;
		logic [2*GRID_BITS-1:0]              waddr;
		logic [GRID_BITS-1:0]                wbit;
		logic [2:0]                          pos;
		logic [2:0]                          live;
		logic [2:0][CW0-1:0]                 cidx;
		logic [2:0][vrt_pkg::MAG_W-1:0]      mag;
		logic [2:0][FRAC_BITS:0]             nxt0;
	} entry_t;

	function automatic logic [1:0] pair_a(input logic [2:0] k);
		unique case (k)
			3'd0, 3'd1: return 2'd0;
			3'd2, 3'd3: return 2'd1;
			default:    return 2'd2;
		endcase
	endfunction

	function automatic logic [1:0] pair_b(input logic [2:0] k);
		unique case (k)
			3'd0:       return 2'd1;
			3'd1, 3'd3: return 2'd2;
			3'd5:       return 2'd1;
			default:    return 2'd0;
		endcase
	endfunction

	entry_t ent;
	vrt_pkg::back_state_t state_q, state_d;

	logic [ROWW-1:0]           mem [ROWS];
	logic [ROWW-1:0]           rd_row_q;
	logic                      mem_we;
	logic [RAW-1:0]            mem_waddr;
	logic [RAW-1:0]            mem_raddr;
	logic [ROWW-1:0]           mem_wdata;
	logic [ROWW-1:0]           wr_row;
	logic [RAW-1:0]            clr_q;

	logic                      wr_set_q;
	logic [RAW-1:0]            wr_addr_q;
	logic [GRID_BITS-1:0]      wr_bit_q;

	logic [CW-1:0]             cell_q [3];
	logic [2:0]                pos_q;
	logic [2:0]                live_q;
	logic [vrt_pkg::MAG_W-1:0] mag_q [3];
	logic [FRAC_BITS:0]        nxt_q [3];
	logic [31:0]               lensq_q;
	logic [MDW-1:0]            md_q [3];
	logic [TW-1:0]             t_q [3];
	logic [PW-1:0]             p_q [3][3];
	logic [RW-1:0]             lin_q [3];
	logic [QW-1:0]             sq_q [3];

	logic [4:0]                su_q;
	logic [31:0]               mul_a;
	logic [31:0]               mul_b;
	logic [63:0]               prod_s1;
	logic [4:0]                dst_s1;
	logic                      dv_s1;

	logic                      first_q;
	logic [1:0]                last_q;
	logic                      lim_ok_q;
	logic [1:0]                pick_q;
	logic [1:0]                pick_d;
	logic                      inside_q;
	logic [GRID_BITS-1:0]      xbit_q;
	logic                      near01, near02, near12;
	logic                      walk_go;
	logic                      solid;
	logic                      inside_d;
	logic [1:0]                hit_axis;
	logic                      out_free;

	logic                      res_hit_q;
	logic [7:0]                res_x_q, res_y_q, res_z_q;
	logic [1:0]                res_axis_q;
	logic                      res_neg_q;
	logic                      out_valid_q;
	logic                      out_hit_q;
	logic [7:0]                out_x_q, out_y_q, out_z_q;
	logic [1:0]                out_axis_q;
	logic                      out_neg_q;

	assign ent = entry_t'(q_data);

	// Axis choice: x only when strictly nearest, then y when nearer than z.
	assign near01 = live_q[0] && (!live_q[1] || (p_q[0][1] < p_q[1][0]));
	assign near02 = live_q[0] && (!live_q[2] || (p_q[0][2] < p_q[2][0]));
	assign near12 = live_q[1] && (!live_q[2] || (p_q[1][2] < p_q[2][1]));
	assign pick_d = (near01 && near02) ? 2'd0 : (near12 ? 2'd1 : 2'd2);

	assign inside_d = (cell_q[0][CW-1:GRID_BITS] == '0) &&
		(cell_q[1][CW-1:GRID_BITS] == '0) && (cell_q[2][CW-1:GRID_BITS] == '0);
	assign walk_go  = first_q ? (max_distance != '0) : lim_ok_q;
	assign solid    = inside_q && rd_row_q[xbit_q];
	assign hit_axis = first_q ? pick_q : last_q;
	assign out_free = !out_valid_q || m_axis_tready;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			vrt_pkg::ST_CLEAR:
				if (clr_q == '1) state_d = vrt_pkg::ST_IDLE;
			vrt_pkg::ST_IDLE:
				if (q_valid) begin
					unique case (ent.kind) inside
						vrt_pkg::K_SET, vrt_pkg::K_CLR: state_d = vrt_pkg::ST_WR_RD;
						vrt_pkg::K_CAST:                state_d = vrt_pkg::ST_SETUP;
						default:                        state_d = vrt_pkg::ST_DONE;
					endcase
				end
			vrt_pkg::ST_WR_RD: state_d = vrt_pkg::ST_WR_WB;
			vrt_pkg::ST_WR_WB: state_d = vrt_pkg::ST_DONE;
			vrt_pkg::ST_SETUP:
				if (su_q == vrt_pkg::SU_END) state_d = vrt_pkg::ST_WALK_CHK;
			vrt_pkg::ST_WALK_CHK:
				state_d = walk_go ? vrt_pkg::ST_WALK_TEST : vrt_pkg::ST_DONE;
			vrt_pkg::ST_WALK_TEST:
				if (solid || !live_q[pick_q]) state_d = vrt_pkg::ST_DONE;
				else state_d = vrt_pkg::ST_WALK_CHK;
			vrt_pkg::ST_DONE:
				if (out_free) state_d = vrt_pkg::ST_IDLE;
			default: state_d = vrt_pkg::ST_CLEAR;
		endcase
	end

	always_comb begin
		logic [1:0] i;
		logic [2:0] k;
		q_ready   = (state_q == vrt_pkg::ST_IDLE);
		clearing  = (state_q == vrt_pkg::ST_CLEAR);
		wr_row    = rd_row_q;
		wr_row[wr_bit_q] = wr_set_q;
		mem_we    = (state_q == vrt_pkg::ST_CLEAR) || (state_q == vrt_pkg::ST_WR_WB);
		mem_waddr = (state_q == vrt_pkg::ST_CLEAR) ? clr_q : wr_addr_q;
		mem_wdata = (state_q == vrt_pkg::ST_CLEAR) ? '0 : wr_row;
		mem_raddr = (state_q == vrt_pkg::ST_WR_RD) ? wr_addr_q
			: {cell_q[2][GRID_BITS-1:0], cell_q[1][GRID_BITS-1:0]};
		i = 2'd0;
		k = 3'd0;
		if (su_q < vrt_pkg::SU_MD) begin
			i = 2'(su_q - vrt_pkg::SU_LEN);
			mul_a = 32'(mag_q[i]);
			mul_b = 32'(mag_q[i]);
		end else if (su_q < vrt_pkg::SU_T) begin
			i = 2'(su_q - vrt_pkg::SU_MD);
			mul_a = 32'(max_distance);
			mul_b = 32'(mag_q[i]);
		end else if (su_q < vrt_pkg::SU_P) begin
			i = 2'(su_q - vrt_pkg::SU_T);
			mul_a = 32'(md_q[i]);
			mul_b = 32'(md_q[i]);
		end else if (su_q < vrt_pkg::SU_R) begin
			k = 3'(su_q - vrt_pkg::SU_P);
			mul_a = 32'(nxt_q[pair_a(k)]);
			mul_b = 32'(mag_q[pair_b(k)]);
		end else if (su_q < vrt_pkg::SU_QL) begin
			i = 2'(su_q - vrt_pkg::SU_R);
			mul_a = 32'(nxt_q[i]);
			mul_b = lensq_q;
		end else if (su_q < vrt_pkg::SU_QH) begin
			i = 2'(su_q - vrt_pkg::SU_QL);
			mul_a = lin_q[i][31:0];
			mul_b = 32'(nxt_q[i]);
		end else begin
			i = 2'(su_q - vrt_pkg::SU_QH);
			mul_a = 32'(lin_q[i][RW-1:32]);
			mul_b = 32'(nxt_q[i]);
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_waddr] <= mem_wdata;
		rd_row_q <= mem[mem_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= vrt_pkg::ST_CLEAR;
			clr_q       <= '0;
			su_q        <= '0;
			dv_s1       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == vrt_pkg::ST_CLEAR) clr_q <= clr_q + RAW'(1);
			if (state_q == vrt_pkg::ST_IDLE) su_q <= '0;
			else if (state_q == vrt_pkg::ST_SETUP && su_q != vrt_pkg::SU_END)
				su_q <= su_q + 5'd1;
			dv_s1 <= (state_q == vrt_pkg::ST_SETUP) && (su_q != vrt_pkg::SU_END);
			if (state_q == vrt_pkg::ST_DONE && out_free) out_valid_q <= 1'b1;
			else if (m_axis_tready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= 64'(mul_a) * 64'(mul_b);
		dst_s1  <= su_q;

		if (state_q == vrt_pkg::ST_IDLE && q_valid) begin
			wr_set_q   <= (ent.kind == vrt_pkg::K_SET);
			wr_addr_q  <= ent.waddr;
			wr_bit_q   <= ent.wbit;
			pos_q      <= ent.pos;
			live_q     <= ent.live;
			lensq_q    <= '0;
			first_q    <= 1'b1;
			res_hit_q  <= 1'b0;
			res_x_q    <= '0;
			res_y_q    <= '0;
			res_z_q    <= '0;
			res_axis_q <= '0;
			res_neg_q  <= 1'b0;
			for (int a = 0; a < 3; a++) begin
				cell_q[a] <= {{(CW-CW0){ent.cidx[a][CW0-1]}}, ent.cidx[a]};
				mag_q[a]  <= ent.mag[a];
				nxt_q[a]  <= ent.nxt0[a];
			end
		end

		if (dv_s1) begin
			if (dst_s1 < vrt_pkg::SU_MD)
				lensq_q <= lensq_q + prod_s1[31:0];
			else if (dst_s1 < vrt_pkg::SU_T)
				md_q[2'(dst_s1 - vrt_pkg::SU_MD)] <= prod_s1[MDW-1:0];
			else if (dst_s1 < vrt_pkg::SU_P)
				t_q[2'(dst_s1 - vrt_pkg::SU_T)] <= prod_s1[TW-1:0];
			else if (dst_s1 < vrt_pkg::SU_R)
				p_q[pair_a(3'(dst_s1 - vrt_pkg::SU_P))][pair_b(3'(dst_s1 - vrt_pkg::SU_P))]
					<= PW'(prod_s1);
			else if (dst_s1 < vrt_pkg::SU_QL)
				lin_q[2'(dst_s1 - vrt_pkg::SU_R)] <= RW'(prod_s1);
			else if (dst_s1 < vrt_pkg::SU_QH)
				sq_q[2'(dst_s1 - vrt_pkg::SU_QL)] <= QW'(prod_s1);
			else
				sq_q[2'(dst_s1 - vrt_pkg::SU_QH)] <= sq_q[2'(dst_s1 - vrt_pkg::SU_QH)]
					+ (QW'(prod_s1) << 32);
		end

		if (state_q == vrt_pkg::ST_WALK_CHK) begin
			pick_q   <= pick_d;
			inside_q <= inside_d;
			xbit_q   <= cell_q[0][GRID_BITS-1:0];
		end

		if (state_q == vrt_pkg::ST_WALK_TEST) begin
			if (solid) begin
				res_hit_q  <= 1'b1;
				res_x_q    <= cell_q[0][7:0];
				res_y_q    <= cell_q[1][7:0];
				res_z_q    <= cell_q[2][7:0];
				res_axis_q <= hit_axis;
				res_neg_q  <= pos_q[hit_axis];
			end else if (live_q[pick_q]) begin
				first_q <= 1'b0;
				last_q  <= pick_q;
				for (int a = 0; a < 3; a++) begin
					if (2'(a) == pick_q) begin
						cell_q[a] <= pos_q[a] ? cell_q[a] + CW'(1) : cell_q[a] - CW'(1);
						// Limit test uses the crossing just taken, before it advances.
						lim_ok_q <= sq_q[a][QW-1:2*FRAC_BITS] < QSW'(t_q[a]);
						// (n + 1)^2 L^2 = n^2 L^2 + 2 n L^2 + L^2, with n in cell units.
						sq_q[a]  <= sq_q[a] + (QW'(lin_q[a]) << (FRAC_BITS + 1))
							+ (QW'(lensq_q) << (2 * FRAC_BITS));
						lin_q[a] <= lin_q[a] + (RW'(lensq_q) << FRAC_BITS);
						for (int b = 0; b < 3; b++) begin
							if (b != a) p_q[a][b] <= p_q[a][b] + (PW'(mag_q[b]) << FRAC_BITS);
						end
					end
				end
			end
		end

		if (state_q == vrt_pkg::ST_DONE && out_free) begin
			out_hit_q  <= res_hit_q;
			out_x_q    <= res_x_q;
			out_y_q    <= res_y_q;
			out_z_q    <= res_z_q;
			out_axis_q <= res_axis_q;
			out_neg_q  <= res_neg_q;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = out_hit_q;
	assign m_axis_tdata  = {5'b0, out_neg_q, out_axis_q, out_z_q, out_y_q, out_x_q};

`ifndef SYNTHESIS
	a_mem_write_states: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (state_q == vrt_pkg::ST_CLEAR || state_q == vrt_pkg::ST_WR_WB))
		else $error("occupancy written outside clear or write-back");
	a_done_loads_output: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == vrt_pkg::ST_DONE && out_free) |=> out_valid_q)
		else $error("finished item did not reach the output register");
	a_setup_to_walk: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == vrt_pkg::ST_SETUP && su_q == vrt_pkg::SU_END)
		|=> state_q == vrt_pkg::ST_WALK_CHK)
		else $error("setup sequence did not hand over to the walk");
	a_step_clears_first: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == vrt_pkg::ST_WALK_TEST && !solid && live_q[pick_q])
		|=> (state_q == vrt_pkg::ST_WALK_CHK && !first_q))
		else $error("grid step did not return to the limit check");
`endif

endmodule

// ===== tb/vrt_checker.sv =====
`timescale 1ns / 1ps

module vrt_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_axis_tvalid,
	input  logic                           s_axis_tready,
	input  logic [vrt_pkg::IN_DATA_W-1:0]  s_axis_tdata,
	input  logic [1:0]                     s_axis_tuser,
	input  logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	input  logic [vrt_pkg::OUT_DATA_W-1:0] m_axis_tdata,
	input  logic [0:0]                     m_axis_tuser,
	input  logic                           cfg_valid,
	input  logic                           cfg_ready,
	input  logic [vrt_pkg::MAXD_W-1:0]     cfg_data,
	output int                             error_count,
	output int                             outstanding
);

	localparam logic [63:0] ONE_CELL = 64'd1 << vrt_pkg::FRAC_BITS_DEF;

	typedef struct packed {
		logic            hit;
		logic [7:0]      x;
		logic [7:0]      y;
		logic [7:0]      z;
		logic [1:0]      axis;
		logic            negative;
	} ray_result_t;

	ray_result_t      ray_results[$];
	bit               occupied[0:32767];
	logic [7:0]       limit;
	logic [63:0]      cross_dist[3];
	logic [63:0]      dir_mag[3];
	bit               axis_live[3];

	function automatic bit solid_at(int x, int y, int z);
		if (x < 0 || y < 0 || z < 0 || x > 31 || y > 31 || z > 31)
			return 0;
		return occupied[{z[4:0], y[4:0], x[4:0]}];
	endfunction

	function automatic bit crosses_first(int a, int b);
		if (!axis_live[a])
			return 0;
		if (!axis_live[b])
			return 1;
		return cross_dist[a] * dir_mag[b] < cross_dist[b] * dir_mag[a];
	endfunction

	function automatic int nearest_axis();
		if (crosses_first(0, 1) && crosses_first(0, 2))
			return 0;
		if (crosses_first(1, 2))
			return 1;
		return 2;
	endfunction

	function automatic ray_result_t trace_word(logic [1:0] op,
			logic [vrt_pkg::IN_DATA_W-1:0] d);
		ray_result_t       r;
		int                cidx[3];
		bit                positive[3];
		logic signed [23:0] org;
		logic signed [15:0] dir;
		logic [127:0]      lensq;
		logic [127:0]      lhs;
		logic [127:0]      rhs;
		logic [63:0]       last_num;
		int                last;
		int                a;
		bit                first;
		bit                go;
		r = '0;
		if (op == vrt_pkg::OP_SET || op == vrt_pkg::OP_CLR) begin
			occupied[{d[vrt_pkg::CZ_LSB+:5], d[vrt_pkg::CY_LSB+:5], d[vrt_pkg::CX_LSB+:5]}]
				= (op == vrt_pkg::OP_SET);
			return r;
		end
		if (op != vrt_pkg::OP_CAST)
			return r;
		lensq = 0;
		for (a = 0; a < 3; a++) begin
			org = d[vrt_pkg::ORG_LSB + vrt_pkg::ORG_W*a +: vrt_pkg::ORG_W];
			dir = d[vrt_pkg::DIR_LSB + vrt_pkg::DIR_W*a +: vrt_pkg::DIR_W];
			cidx[a] = int'(org >>> vrt_pkg::FRAC_BITS_DEF);
			positive[a] = dir > 0;
			axis_live[a] = dir != 0;
			dir_mag[a] = dir < 0 ? 64'(-int'(dir)) : 64'(int'(dir));
			cross_dist[a] = positive[a] ? ONE_CELL - 64'(org[15:0]) : 64'(org[15:0]);
			lensq += 128'(dir_mag[a] * dir_mag[a]);
		end
		if (lensq == 0)
			return r;
		first = 1;
		last = 0;
		last_num = 0;
		forever begin
			if (first) begin
				go = limit > 0;
			end else begin
				lhs = 128'(last_num) * 128'(last_num) * lensq;
				rhs = (128'(limit) * 128'(limit) * 128'(dir_mag[last]) * 128'(dir_mag[last]))
					<< (2 * vrt_pkg::FRAC_BITS_DEF);
				go = lhs < rhs;
			end
			if (!go)
				break;
			if (solid_at(cidx[0], cidx[1], cidx[2])) begin
				a = first ? nearest_axis() : last;
				r.hit = 1;
				r.x = cidx[0][7:0];
				r.y = cidx[1][7:0];
				r.z = cidx[2][7:0];
				r.axis = a[1:0];
				r.negative = positive[a];
				return r;
			end
			a = nearest_axis();
			if (!axis_live[a])
				break;
			cidx[a] += positive[a] ? 1 : -1;
			last_num = cross_dist[a];
			last = a;
			first = 0;
			cross_dist[a] += ONE_CELL;
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		ray_result_t exp_r;
		int          errs;
		errs = 0;
		if (!arst_n) begin
			for (int i = 0; i < 32768; i++)
				occupied[i] = 0;
			limit = vrt_pkg::MAXD_RESET;
			ray_results.delete();
			error_count <= 0;
			outstanding <= 0;
		end else begin
			if (cfg_valid && cfg_ready)
				limit = cfg_data;
			if (s_axis_tvalid && s_axis_tready)
				ray_results.push_back(trace_word(s_axis_tuser, s_axis_tdata));
			if (m_axis_tvalid && m_axis_tready) begin
				if (ray_results.size() == 0) begin
					$error("result word with no expectation waiting");
					errs++;
				end else begin
					exp_r = ray_results.pop_front();
					if (exp_r.hit !== m_axis_tuser[0]) begin
						$error("hit: expected %0d, got %0d", exp_r.hit, m_axis_tuser[0]);
						errs++;
					end
					if (exp_r.x !== m_axis_tdata[7:0]) begin
						$error("hit_x: expected %0d, got %0d", exp_r.x, m_axis_tdata[7:0]);
						errs++;
					end
					if (exp_r.y !== m_axis_tdata[15:8]) begin
						$error("hit_y: expected %0d, got %0d", exp_r.y, m_axis_tdata[15:8]);
						errs++;
					end
					if (exp_r.z !== m_axis_tdata[23:16]) begin
						$error("hit_z: expected %0d, got %0d", exp_r.z, m_axis_tdata[23:16]);
						errs++;
					end
					if (exp_r.axis !== m_axis_tdata[25:24]) begin
						$error("normal_axis: expected %0d, got %0d", exp_r.axis,
							m_axis_tdata[25:24]);
						errs++;
					end
					if (exp_r.negative !== m_axis_tdata[26]) begin
						$error("normal_negative: expected %0d, got %0d", exp_r.negative,
							m_axis_tdata[26]);
						errs++;
					end
				end
			end
			error_count <= error_count + errs;
			outstanding <= ray_results.size();
		end
	end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

	logic                             clk;
	logic                             arst_n;
	logic                             s_axis_tvalid;
	logic                             s_axis_tready;
	logic [vrt_pkg::IN_DATA_W-1:0]    s_axis_tdata;
	logic [1:0]                       s_axis_tuser;
	logic                             m_axis_tvalid;
	logic                             m_axis_tready;
	logic [vrt_pkg::OUT_DATA_W-1:0]   m_axis_tdata;
	logic [0:0]                       m_axis_tuser;
	logic                             cfg_valid;
	logic                             cfg_ready;
	logic [vrt_pkg::MAXD_W-1:0]       cfg_data;
	int                               error_count;
	int                               outstanding;
	int                               words_taken;

	voxel_ray_traversal dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	vrt_checker u_checker (.*);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		#50ms;
		$display("Mismatches found");
		$finish;
	end

	task automatic send_word(logic [1:0] op, logic [vrt_pkg::IN_DATA_W-1:0] d);
		int gap;
		gap = $urandom_range(0, 3);
		if (gap != 0) begin
			s_axis_tvalid <= 0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1;
		s_axis_tuser <= op;
		s_axis_tdata <= d;
		do @(posedge clk); while (!s_axis_tready);
	endtask

	task automatic write_cell(logic [1:0] op, logic [4:0] x, logic [4:0] y, logic [4:0] z);
		logic [vrt_pkg::IN_DATA_W-1:0] d;
		d = vrt_pkg::IN_DATA_W'({$urandom, $urandom, $urandom, $urandom, $urandom});
		d[vrt_pkg::CX_LSB+:5] = x;
		d[vrt_pkg::CY_LSB+:5] = y;
		d[vrt_pkg::CZ_LSB+:5] = z;
		send_word(op, d);
	endtask

	task automatic cast_ray(logic [23:0] ox, logic [23:0] oy, logic [23:0] oz,
			logic [15:0] dx, logic [15:0] dy, logic [15:0] dz);
		logic [vrt_pkg::IN_DATA_W-1:0] d;
		d = vrt_pkg::IN_DATA_W'({$urandom, $urandom, $urandom, $urandom, $urandom});
		d[134:0] = {dz, dy, dx, oz, oy, ox, d[14:0]};
		d[135] = 0;
		send_word(vrt_pkg::OP_CAST, d);
	endtask

	// The limit may only change once every word in flight has come out.
	task automatic set_limit(logic [7:0] v);
		s_axis_tvalid <= 0;
		@(negedge clk);
		while (outstanding != 0) @(negedge clk);
		@(posedge clk);
		cfg_valid <= 1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 0;
	endtask

	function automatic logic [23:0] near_coord();
		if ($urandom_range(0, 9) == 0)
			return 24'($urandom);
		return 24'($urandom_range(0, 8 << 16));
	endfunction

	function automatic logic [15:0] rand_dir();
		if ($urandom_range(0, 4) == 0)
			return '0;
		return 16'($urandom);
	endfunction

	initial begin
		m_axis_tready = 0;
		words_taken = 0;
		@(posedge arst_n);
		forever begin
			int gap;
			gap = $urandom_range(0, 3);
			if (words_taken == 40)
				gap = 400;
			if (words_taken > 200 && words_taken < 240)
				gap = 0;
			if (gap != 0) begin
				m_axis_tready <= 0;
				repeat (gap) @(posedge clk);
			end
			m_axis_tready <= 1;
			do @(posedge clk); while (!m_axis_tvalid);
			words_taken++;
		end
	end

	initial begin
		logic [7:0] limits[5];
		int counts[5];
		int pick;
		limits = '{8'd4, 8'd12, 8'd1, 8'd30, 8'd255};
		counts = '{90, 90, 60, 90, 20};
		arst_n = 0;
		s_axis_tvalid = 0;
		s_axis_tdata = '0;
		s_axis_tuser = vrt_pkg::OP_NOP;
		cfg_valid = 0;
		cfg_data = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1;

		// Directed words with the reset limit.
		write_cell(vrt_pkg::OP_SET, 0, 0, 0);
		write_cell(vrt_pkg::OP_SET, 31, 31, 31);
		write_cell(vrt_pkg::OP_SET, 3, 0, 0);
		write_cell(vrt_pkg::OP_SET, 0, 3, 0);
		write_cell(vrt_pkg::OP_SET, 0, 0, 3);
		cast_ray(24'h008000, 24'h008000, 24'h008000, 16'h4000, 16'h0, 16'h0);
		cast_ray(24'h018000, 24'h008000, 24'h008000, 16'h4000, 16'h0, 16'h0);
		cast_ray(24'h058000, 24'h008000, 24'h008000, 16'hC000, 16'h0, 16'h0);
		cast_ray(24'h008000, 24'h018000, 24'h008000, 16'h0, 16'h7FFF, 16'h0);
		cast_ray(24'h008000, 24'h008000, 24'h058000, 16'h0, 16'h0, 16'h8000);
		cast_ray(24'h020000, 24'h020000, 24'h020000, 16'h2000, 16'h2000, 16'h2000);
		cast_ray(24'hFD0000, 24'h008000, 24'h008000, 16'h4000, 16'h0, 16'h0);
		cast_ray(24'h800000, 24'h7FFFFF, 24'h800000, 16'h1000, 16'hF000, 16'h1000);
		cast_ray(24'h010000, 24'h010000, 24'h010000, 16'h0, 16'h0, 16'h0);
		cast_ray(24'h1F8000, 24'h1F8000, 24'h1F8000, 16'h0, 16'h0, 16'h0);
		write_cell(vrt_pkg::OP_CLR, 3, 0, 0);
		cast_ray(24'h018000, 24'h008000, 24'h008000, 16'h4000, 16'h0, 16'h0);
		write_cell(vrt_pkg::OP_NOP, 5, 5, 5);
		set_limit(8'd0);
		cast_ray(24'h008000, 24'h008000, 24'h008000, 16'h4000, 16'h0, 16'h0);
		set_limit(8'd255);
		cast_ray(24'h1E8000, 24'h1F8000, 24'h1F8000, 16'hC000, 16'h0, 16'h0);
		cast_ray(24'h1F8000, 24'h1F8000, 24'h008000, 16'h0, 16'h0, 16'h4000);
		cast_ray(24'h108000, 24'h108000, 24'h108000, 16'h0123, 16'h3001, 16'hFE00);

		for (int p = 0; p < 5; p++) begin
			set_limit(limits[p]);
			for (int i = 0; i < counts[p]; i++) begin
				pick = $urandom_range(0, 99);
				if (pick < 45)
					cast_ray(near_coord(), near_coord(), near_coord(),
						rand_dir(), rand_dir(), rand_dir());
				else if (pick < 80)
					write_cell(vrt_pkg::OP_SET, 5'($urandom_range(0, 7)),
						5'($urandom_range(0, 7)), 5'($urandom_range(0, 7)));
				else if (pick < 90)
					write_cell(vrt_pkg::OP_CLR, 5'($urandom_range(0, 7)),
						5'($urandom_range(0, 7)), 5'($urandom_range(0, 7)));
				else if (pick < 96)
					write_cell(pick[0] ? vrt_pkg::OP_SET : vrt_pkg::OP_CLR, 5'($urandom),
						5'($urandom), 5'($urandom));
				else
					send_word(vrt_pkg::OP_NOP,
						vrt_pkg::IN_DATA_W'({$urandom, $urandom, $urandom, $urandom, $urandom}));
			end
		end
		s_axis_tvalid <= 0;
		@(negedge clk);
		while (outstanding != 0) @(negedge clk);
		repeat (100) @(posedge clk);
		if (error_count == 0 && outstanding == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
